// ===== rtl/multi_slot_task_deadline_monitor_defines.svh =====
// ----------------------------------------------------------------------------
// multi slot task deadline monitor assertion macros
// shared concurrent assertion forms used by the monitor top level
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_TASK_DEADLINE_MONITOR_DEFINES_SVH
`define MULTI_SLOT_TASK_DEADLINE_MONITOR_DEFINES_SVH

// same-cycle implication
`define MSTDM_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mstdm assertion failed");

// next-cycle implication
`define MSTDM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mstdm assertion failed");

`endif

// ===== rtl/mstdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mstdm package
// shared constants, request codes and types of the deadline monitor
// ----------------------------------------------------------------------------
package mstdm_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_W  = 3;
  localparam int TIME_W  = 32;
  localparam int DUR_W   = 32;
  localparam int GUARD_W = 16;
  localparam int COUNT_W = 4;
  localparam int REQ_W   = 3;

  localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BEGIN  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_END    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CHECK  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd6;

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              gt;
  } alu_rsp_t;

  typedef struct packed {
    logic               status;
    logic [SLOT_W-1:0]  new_slot;
    logic               is_pending;
    logic               all_ok;
    logic [SLOT_W-1:0]  late_slot;
    logic [COUNT_W-1:0] used_count;
  } rsp_t;

endpackage

// ===== rtl/mstdm_if.sv =====
// ----------------------------------------------------------------------------
// mstdm channel interfaces
// request, response and configuration valid/ready channels
// ----------------------------------------------------------------------------
interface mstdm_req_if;
  logic                          valid;
  logic                          ready;
  logic [mstdm_pkg::REQ_W-1:0]   req_type;
  logic [mstdm_pkg::SLOT_W-1:0]  slot;
  logic [mstdm_pkg::DUR_W-1:0]   duration;

  modport source (output valid, req_type, slot, duration, input ready);
  modport sink   (input valid, req_type, slot, duration, output ready);
endinterface

interface mstdm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [mstdm_pkg::SLOT_W-1:0]  new_slot;
  logic                          is_pending;
  logic                          all_ok;
  logic [mstdm_pkg::SLOT_W-1:0]  late_slot;
  logic [mstdm_pkg::COUNT_W-1:0] used_count;

  modport source (output valid, status, new_slot, is_pending, all_ok, late_slot, used_count,
                  input ready);
  modport sink   (input valid, status, new_slot, is_pending, all_ok, late_slot, used_count,
                  output ready);
endinterface

interface mstdm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mstdm_pkg::GUARD_W-1:0] guard_time;

  modport source (output valid, guard_time, input ready);
  modport sink   (input valid, guard_time, output ready);
endinterface

// ===== rtl/mstdm_alu.sv =====
// ----------------------------------------------------------------------------
// mstdm shared arithmetic unit
// one time-width adder and one unsigned greater-than compare
// ----------------------------------------------------------------------------
module mstdm_alu (
  input  mstdm_pkg::alu_req_t alu_req_i,
  output mstdm_pkg::alu_rsp_t alu_rsp_o
);

  assign alu_rsp_o.sum = alu_req_i.a + alu_req_i.b;
  assign alu_rsp_o.gt  = alu_req_i.a > alu_req_i.b;

endmodule

// ===== rtl/mstdm_seq.sv =====
// ----------------------------------------------------------------------------
// mstdm sequencer
// slot table, deadline memory and the request sequencer around the shared unit
// ----------------------------------------------------------------------------
module mstdm_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mstdm_pkg::REQ_W-1:0]    req_type_i,
  input  logic [mstdm_pkg::SLOT_W-1:0]   slot_i,
  input  logic [mstdm_pkg::DUR_W-1:0]    duration_i,
  input  logic [mstdm_pkg::GUARD_W-1:0]  guard_i,
  output logic                           idle_o,
  output logic                           done_o,
  input  logic                           done_ready_i,
  output mstdm_pkg::rsp_t                result_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_ADD  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_READ = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  localparam logic [mstdm_pkg::SLOT_W-1:0] LAST_IDX = mstdm_pkg::SLOT_W'(mstdm_pkg::SLOTS - 1);

  state_e state_q, state_d;

  logic [mstdm_pkg::SLOTS-1:0]   in_use_q, in_use_d;
  logic [mstdm_pkg::SLOTS-1:0]   open_q, open_d;
  logic [mstdm_pkg::TIME_W-1:0]  now_q, now_d;
  logic [mstdm_pkg::SLOT_W-1:0]  overdue_q, overdue_d;
  logic [mstdm_pkg::COUNT_W-1:0] count_q, count_d;
  logic [mstdm_pkg::SLOT_W-1:0]  idx_q, idx_d;

  logic [mstdm_pkg::REQ_W-1:0]   req_q;
  logic [mstdm_pkg::SLOT_W-1:0]  slot_q;
  logic [mstdm_pkg::DUR_W-1:0]   dur_q;
  logic [mstdm_pkg::TIME_W-1:0]  acc_q, acc_d;

  logic                          status_q, status_d;
  logic [mstdm_pkg::SLOT_W-1:0]  new_slot_q, new_slot_d;
  logic                          pend_q, pend_d;
  logic                          ok_q, ok_d;

  logic [mstdm_pkg::TIME_W-1:0]  deadline_mem [mstdm_pkg::SLOTS];
  logic [mstdm_pkg::TIME_W-1:0]  rdata_q;
  logic                          mem_we;

  mstdm_pkg::alu_req_t alu_req;
  mstdm_pkg::alu_rsp_t alu_rsp;

  mstdm_alu u_alu (
    .alu_req_i (alu_req),
    .alu_rsp_o (alu_rsp)
  );

  // shared unit operand select
  always_comb begin
    alu_req.a = now_q;
    alu_req.b = mstdm_pkg::TIME_W'(dur_q);
    case (state_q)
      S_EXEC: begin
        if (req_q == mstdm_pkg::REQ_TICK) begin
          alu_req.b = mstdm_pkg::TIME_W'(1);
        end
      end
      S_ADD: begin
        alu_req.a = acc_q;
        alu_req.b = mstdm_pkg::TIME_W'(guard_i);
      end
      S_CMP: begin
        alu_req.b = rdata_q;
      end
      default: begin
        alu_req.a = now_q;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    in_use_d   = in_use_q;
    open_d     = open_q;
    now_d      = now_q;
    overdue_d  = overdue_q;
    count_d    = count_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    status_d   = status_q;
    new_slot_d = new_slot_q;
    pend_d     = pend_q;
    ok_d       = ok_q;
    mem_we     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d    = S_EXEC;
          idx_d      = '0;
          status_d   = 1'b0;
          new_slot_d = '0;
          pend_d     = 1'b0;
          ok_d       = 1'b0;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (req_q)
          mstdm_pkg::REQ_CREATE: begin
            state_d = S_SCAN;
          end
          mstdm_pkg::REQ_FREE: begin
            if (in_use_q[slot_q] && count_q != '0) begin
              count_d = count_q - mstdm_pkg::COUNT_W'(1);
            end
            in_use_d[slot_q] = 1'b0;
            open_d[slot_q]   = 1'b0;
          end
          mstdm_pkg::REQ_BEGIN: begin
            if (!open_q[slot_q]) begin
              acc_d   = alu_rsp.sum;
              state_d = S_ADD;
            end
          end
          mstdm_pkg::REQ_END: begin
            open_d[slot_q] = 1'b0;
          end
          mstdm_pkg::REQ_QUERY: begin
            pend_d = open_q[slot_q];
          end
          mstdm_pkg::REQ_CHECK: begin
            state_d = S_READ;
          end
          mstdm_pkg::REQ_TICK: begin
            now_d = alu_rsp.sum;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_ADD: begin
        mem_we         = 1'b1;
        open_d[slot_q] = 1'b1;
        state_d        = S_DONE;
      end
      S_SCAN: begin
        if (!in_use_q[idx_q]) begin
          in_use_d[idx_q] = 1'b1;
          open_d[idx_q]   = 1'b0;
          count_d         = count_q + mstdm_pkg::COUNT_W'(1);
          new_slot_d      = idx_q;
          state_d         = S_DONE;
        end else if (idx_q == LAST_IDX) begin
          status_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          idx_d = idx_q + mstdm_pkg::SLOT_W'(1);
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (in_use_q[idx_q] && open_q[idx_q] && alu_rsp.gt) begin
          overdue_d = idx_q;
          state_d   = S_DONE;
        end else if (idx_q == LAST_IDX) begin
          ok_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + mstdm_pkg::SLOT_W'(1);
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (done_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_use_q  <= '0;
      open_q    <= '0;
      now_q     <= '0;
      overdue_q <= '0;
      count_q   <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      in_use_q  <= in_use_d;
      open_q    <= open_d;
      now_q     <= now_d;
      overdue_q <= overdue_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) begin
      req_q  <= req_type_i;
      slot_q <= slot_i;
      dur_q  <= duration_i;
    end
    acc_q      <= acc_d;
    status_q   <= status_d;
    new_slot_q <= new_slot_d;
    pend_q     <= pend_d;
    ok_q       <= ok_d;
  end

  // deadline memory, registered read at the scan index; written in the add step
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      deadline_mem[slot_q] <= alu_rsp.sum;
    end
    rdata_q <= deadline_mem[idx_q];
  end

  assign idle_o              = state_q == S_IDLE;
  assign done_o              = state_q == S_DONE;
  assign result_o.status     = status_q;
  assign result_o.new_slot   = new_slot_q;
  assign result_o.is_pending = pend_q;
  assign result_o.all_ok     = ok_q;
  assign result_o.late_slot  = overdue_q;
  assign result_o.used_count = count_q;

endmodule

// ===== rtl/multi_slot_task_deadline_monitor.sv =====
// ----------------------------------------------------------------------------
// multi slot task deadline monitor
// watchdog slot table with create, free, begin, end, query, check and tick
// ----------------------------------------------------------------------------
// channel  dir  payload
// req_i    in   req_type, slot, duration
// rsp_o    out  status, new_slot, is_pending, all_ok, late_slot, used_count
// cfg_i    in   guard_time
//
// free, end, query, tick and unused codes run exec then done; begin runs exec,
// add unless open, then done; create scans for a free slot, one slot per cycle
// check walks the slots, a deadline memory read then a compare for each
// one request at a time; the output register takes the result so the next request
// can start while it waits; no clearing pass after reset
// ----------------------------------------------------------------------------
`include "multi_slot_task_deadline_monitor_defines.svh"

module multi_slot_task_deadline_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  mstdm_req_if.sink   req_i,
  mstdm_rsp_if.source rsp_o,
  mstdm_cfg_if.sink   cfg_i
);

  logic                          seq_idle;
  logic                          seq_done;
  logic                          seq_done_ready;
  mstdm_pkg::rsp_t               seq_result;
  logic                          req_accept;
  logic [mstdm_pkg::GUARD_W-1:0] guard_q;
  logic                          out_valid_q;
  mstdm_pkg::rsp_t               out_q;
  logic                          count_in_range;
  logic                          table_full;

  assign req_accept     = req_i.valid && req_i.ready;
  assign req_i.ready    = seq_idle;
  assign cfg_i.ready    = 1'b1;
  assign seq_done_ready = !out_valid_q || rsp_o.ready;

  mstdm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (req_accept),
    .req_type_i   (req_i.req_type),
    .slot_i       (req_i.slot),
    .duration_i   (req_i.duration),
    .guard_i      (guard_q),
    .idle_o       (seq_idle),
    .done_o       (seq_done),
    .done_ready_i (seq_done_ready),
    .result_o     (seq_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        guard_q <= cfg_i.guard_time;
      end
      if (seq_done && seq_done_ready) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done && seq_done_ready) begin
      out_q <= seq_result;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.new_slot   = out_q.new_slot;
  assign rsp_o.is_pending = out_q.is_pending;
  assign rsp_o.all_ok     = out_q.all_ok;
  assign rsp_o.late_slot  = out_q.late_slot;
  assign rsp_o.used_count = out_q.used_count;

  assign count_in_range = seq_result.used_count <= mstdm_pkg::COUNT_W'(mstdm_pkg::SLOTS);
  assign table_full     = seq_result.used_count == mstdm_pkg::COUNT_W'(mstdm_pkg::SLOTS);

  // a request keeps the sequencer busy in the next cycle
  `MSTDM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_accept, !req_i.ready)
  // the in-use count never passes the table size
  `MSTDM_ASSERT_NOW(a_count_bound, clk_i, rst_ni, seq_done, count_in_range)
  // a failed create means every slot is taken
  `MSTDM_ASSERT_NOW(a_full_on_fail, clk_i, rst_ni, seq_done && seq_result.status, table_full)

endmodule
